### sv/pds_pkg.sv
// Package for the PLL divider search block: field widths, register map,
// reset values and default search limits. No dependencies.
package pds_pkg;

	localparam int unsigned FREQ_W = 22;
	localparam int unsigned NUM_W  = 12;
	localparam int unsigned DEN_W  = 16;
	localparam int unsigned SET_W  = 8;
	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;

	localparam int unsigned MAX_MULT_DEF    = 128;
	localparam int unsigned MAX_OUT_DIV_DEF = 128;

	// largest pre-divider the result field can carry
	localparam logic [SET_W-1:0] DIV_CAP = 8'd255;

	localparam logic [FREQ_W-1:0] VCO_MIN_RST  = 22'd800000;
	localparam logic [FREQ_W-1:0] VCO_MAX_RST  = 22'd1500000;
	localparam logic [FREQ_W-1:0] PFD_MIN_RST  = 22'd70000;
	localparam logic [FREQ_W-1:0] PFD_MAX_RST  = 22'd450000;
	localparam logic [FREQ_W-1:0] FOUT_MIN_RST = 22'd6250;

	typedef enum logic [2:0] {
		REG_VCO_MIN  = 3'd0,
		REG_VCO_MAX  = 3'd1,
		REG_PFD_MIN  = 3'd2,
		REG_PFD_MAX  = 3'd3,
		REG_FOUT_MIN = 3'd4
	} reg_idx_t;

endpackage

### sv/pll_divider_search.sv
// PLL divider search: finds pre-divider, multiplier and output divider for
// a requested ratio. Depends on pds_pkg.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | in_valid, in_ready, fin_khz, ratio_*      | request in
//   out     | out_valid, out_ready, found, multiplier,  | result out
//           | pre_divider, out_divider                  |
//   cfg     | psel, penable, pwrite, paddr, pwdata,     | APB slave
//           | prdata, pready                            |
//
// A request is accepted, searched and handed over; the search ends early when the
// pre-divider bound is passed. For each pre-divider tried the bounds are scaled, then
// up to MAX_MULT-1 multipliers are tried, each through the window check, the divider
// and the output check as far as it passes; the 30x8 multiplier is shared by all
// products and the divider is an 8-step restoring divider.
// in_ready is high only while the sequencer idles; a finished result sits in
// the output register so the next request can enter while it waits, and a full
// output register holds the sequencer in its done state.
// Reset clears the sequencer, the output valid and restores register values.
module pll_divider_search #(
	parameter int unsigned MAX_MULT    = pds_pkg::MAX_MULT_DEF,
	parameter int unsigned MAX_OUT_DIV = pds_pkg::MAX_OUT_DIV_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [pds_pkg::FREQ_W-1:0]   fin_khz,
	input  logic [pds_pkg::NUM_W-1:0]    ratio_num,
	input  logic [pds_pkg::DEN_W-1:0]    ratio_den,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         found,
	output logic [pds_pkg::SET_W-1:0]    multiplier,
	output logic [pds_pkg::SET_W-1:0]    pre_divider,
	output logic [pds_pkg::SET_W-1:0]    out_divider,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pds_pkg::ADDR_W-1:0]   paddr,
	input  logic [pds_pkg::DATA_W-1:0]   pwdata,
	output logic [pds_pkg::DATA_W-1:0]   prdata,
	output logic                         pready
);
	import pds_pkg::*;

	localparam int unsigned PROD_W = 38;
	localparam int unsigned PRE_W  = 30;
	localparam int unsigned QW     = NUM_W + SET_W;
	localparam int unsigned LHS_W  = DEN_W + SET_W;
	localparam int unsigned SH_W   = QW + SET_W;
	localparam logic [SET_W-1:0] MaxMultW   = SET_W'(MAX_MULT);
	localparam logic [SET_W-1:0] MaxOutDivW = SET_W'(MAX_OUT_DIV);

	typedef enum logic [3:0] {
		S_IDLE, S_DBND, S_VMIN, S_VMAX, S_FOUT, S_QNUM, S_QSAVE,
		S_FM, S_LHS, S_WIN, S_DIV, S_DIVEND, S_OUTM, S_OUTCHK, S_DONE
	} state_t;

	state_t state_q;

	logic [FREQ_W-1:0] vco_min_q, vco_max_q, pfd_min_q, pfd_max_q, fout_min_q;
	logic [FREQ_W-1:0] fin_q;
	logic [NUM_W-1:0]  num_q;
	logic [DEN_W-1:0]  den_q;
	logic [SET_W-1:0]  d_q, m_q, quo_q;
	logic [PRE_W-1:0]  vmin_d_q, vmax_d_q, fout_d_q, fm_q;
	logic [QW-1:0]     q_q;
	logic [LHS_W-1:0]  rem_q;
	logic [2:0]        div_bit_q;
	logic              res_found_q;
	logic [SET_W-1:0]  res_m_q, res_d_q, res_o_q;
	logic              out_valid_q, found_q;
	logic [SET_W-1:0]  mult_q, pre_q, odiv_q;

	logic [PRE_W-1:0]  mul_a;
	logic [SET_W-1:0]  mul_b;
	logic [PROD_W-1:0] prod_q;

	logic [LHS_W-1:0]  lhs;
	logic [SH_W-1:0]   q_sh8, div_sh, rem_ext;
	logic              fm_in_win, too_big, div_ok, out_ok, step_m, last_m, last_d;
	logic              load_out;
	logic              cfg_wr;
	reg_idx_t          cfg_idx;

	// configuration registers
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_idx = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vco_min_q  <= VCO_MIN_RST;
			vco_max_q  <= VCO_MAX_RST;
			pfd_min_q  <= PFD_MIN_RST;
			pfd_max_q  <= PFD_MAX_RST;
			fout_min_q <= FOUT_MIN_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_VCO_MIN:  vco_min_q  <= pwdata[FREQ_W-1:0];
				REG_VCO_MAX:  vco_max_q  <= pwdata[FREQ_W-1:0];
				REG_PFD_MIN:  pfd_min_q  <= pwdata[FREQ_W-1:0];
				REG_PFD_MAX:  pfd_max_q  <= pwdata[FREQ_W-1:0];
				REG_FOUT_MIN: fout_min_q <= pwdata[FREQ_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_VCO_MIN:  prdata = {{(DATA_W-FREQ_W){1'b0}}, vco_min_q};
			REG_VCO_MAX:  prdata = {{(DATA_W-FREQ_W){1'b0}}, vco_max_q};
			REG_PFD_MIN:  prdata = {{(DATA_W-FREQ_W){1'b0}}, pfd_min_q};
			REG_PFD_MAX:  prdata = {{(DATA_W-FREQ_W){1'b0}}, pfd_max_q};
			REG_FOUT_MIN: prdata = {{(DATA_W-FREQ_W){1'b0}}, fout_min_q};
			default:      prdata = '0;
		endcase
	end

	// shared multiplier: operands picked by state, product registered
	always_comb begin
		unique case (state_q)
			S_DBND:  begin mul_a = PRE_W'(pfd_min_q);  mul_b = d_q;   end
			S_VMIN:  begin mul_a = PRE_W'(vco_min_q);  mul_b = d_q;   end
			S_VMAX:  begin mul_a = PRE_W'(vco_max_q);  mul_b = d_q;   end
			S_FOUT:  begin mul_a = PRE_W'(fout_min_q); mul_b = d_q;   end
			S_QNUM:  begin mul_a = PRE_W'(num_q);      mul_b = d_q;   end
			S_FM:    begin mul_a = PRE_W'(fin_q);      mul_b = m_q;   end
			S_LHS:   begin mul_a = PRE_W'(den_q);      mul_b = m_q;   end
			S_OUTM:  begin mul_a = fout_d_q;           mul_b = quo_q; end
			default: begin mul_a = '0;                 mul_b = '0;    end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
	end

	always_comb begin
		lhs       = prod_q[LHS_W-1:0];
		fm_in_win = (fm_q >= vmin_d_q) && (fm_q <= vmax_d_q);
		q_sh8     = {q_q, 8'b0};
		too_big   = SH_W'(lhs) >= q_sh8;
		div_sh    = SH_W'(q_q) << div_bit_q;
		rem_ext   = SH_W'(rem_q);
		div_ok    = (rem_q == '0) && (quo_q != '0) && (quo_q <= MaxOutDivW);
		out_ok    = PROD_W'(fm_q) >= prod_q;
		last_m    = m_q <= 8'd2;
		last_d    = d_q == DIV_CAP;
		step_m    = ((state_q == S_WIN) &&
		             (!fm_in_win || ((q_q == '0) ? (lhs != '0) : too_big))) ||
		            ((state_q == S_DIVEND) && !div_ok) ||
		            ((state_q == S_OUTCHK) && !out_ok);
		load_out  = (state_q == S_DONE) && (!out_valid_q || out_ready);
	end

	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			found_q     <= 1'b0;
			mult_q      <= '0;
			pre_q       <= '0;
			odiv_q      <= '0;
			fin_q       <= '0;
			num_q       <= '0;
			den_q       <= '0;
			d_q         <= '0;
			m_q         <= '0;
			quo_q       <= '0;
			vmin_d_q    <= '0;
			vmax_d_q    <= '0;
			fout_d_q    <= '0;
			fm_q        <= '0;
			q_q         <= '0;
			rem_q       <= '0;
			div_bit_q   <= '0;
			res_found_q <= 1'b0;
			res_m_q     <= '0;
			res_d_q     <= '0;
			res_o_q     <= '0;
		end else begin
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			priority if (step_m) begin
				if (last_m) begin
					if (last_d) begin
						res_found_q <= 1'b0;
						res_m_q     <= '0;
						res_d_q     <= '0;
						res_o_q     <= '0;
						state_q     <= S_DONE;
					end else begin
						d_q     <= d_q + 8'd1;
						state_q <= S_DBND;
					end
				end else begin
					m_q     <= m_q - 8'd1;
					state_q <= S_FM;
				end
			end else begin
				unique case (state_q)
					S_IDLE: begin
						if (in_valid) begin
							fin_q <= fin_khz;
							num_q <= ratio_num;
							den_q <= ratio_den;
							d_q   <= (fin_khz > pfd_max_q) ? 8'd2 : 8'd1;
							if (fin_khz == '0) begin
								res_found_q <= 1'b0;
								res_m_q     <= '0;
								res_d_q     <= '0;
								res_o_q     <= '0;
								state_q     <= S_DONE;
							end else begin
								state_q <= S_DBND;
							end
						end
					end
					S_DBND: state_q <= S_VMIN;
					S_VMIN: begin
						// past the pre-divider bound: d * pfd_min above fin
						if (d_q != 8'd1 && prod_q > PROD_W'(fin_q)) begin
							res_found_q <= 1'b0;
							res_m_q     <= '0;
							res_d_q     <= '0;
							res_o_q     <= '0;
							state_q     <= S_DONE;
						end else begin
							state_q <= S_VMAX;
						end
					end
					S_VMAX: begin
						vmin_d_q <= prod_q[PRE_W-1:0];
						state_q  <= S_FOUT;
					end
					S_FOUT: begin
						vmax_d_q <= prod_q[PRE_W-1:0];
						state_q  <= S_QNUM;
					end
					S_QNUM: begin
						fout_d_q <= prod_q[PRE_W-1:0];
						state_q  <= S_QSAVE;
					end
					S_QSAVE: begin
						q_q     <= prod_q[QW-1:0];
						m_q     <= MaxMultW;
						state_q <= S_FM;
					end
					S_FM: state_q <= S_LHS;
					S_LHS: begin
						fm_q    <= prod_q[PRE_W-1:0];
						state_q <= S_WIN;
					end
					S_WIN: begin
						// window holds; zero numerator with zero lhs takes o = 1
						if (q_q == '0) begin
							quo_q   <= 8'd1;
							state_q <= S_OUTM;
						end else begin
							rem_q     <= lhs;
							quo_q     <= '0;
							div_bit_q <= 3'd7;
							state_q   <= S_DIV;
						end
					end
					S_DIV: begin
						if (rem_ext >= div_sh) begin
							rem_q            <= rem_q - div_sh[LHS_W-1:0];
							quo_q[div_bit_q] <= 1'b1;
						end
						if (div_bit_q == 3'd0)
							state_q <= S_DIVEND;
						else
							div_bit_q <= div_bit_q - 3'd1;
					end
					S_DIVEND: state_q <= S_OUTM;
					S_OUTM:   state_q <= S_OUTCHK;
					S_OUTCHK: begin
						res_found_q <= 1'b1;
						res_m_q     <= m_q;
						res_d_q     <= d_q;
						res_o_q     <= quo_q;
						state_q     <= S_DONE;
					end
					S_DONE: begin
						// hand over once the output register is free
						if (load_out) begin
							found_q     <= res_found_q;
							mult_q      <= res_m_q;
							pre_q       <= res_d_q;
							odiv_q      <= res_o_q;
							state_q     <= S_IDLE;
						end
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = found_q;
	assign multiplier  = mult_q;
	assign pre_divider = pre_q;
	assign out_divider = odiv_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("sequencer still idle after taking a request");

	a_found_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> multiplier >= 8'd2 && multiplier <= MaxMultW &&
		pre_divider != '0 && out_divider != '0 && out_divider <= MaxOutDivW)
		else $error("found result with settings out of range");

	a_miss_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> multiplier == '0 && pre_divider == '0 &&
		out_divider == '0)
		else $error("miss result carries nonzero settings");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> q_q != '0 && SH_W'(rem_q) < (div_sh << 1))
		else $error("divider running on zero divisor or bad remainder");

endmodule

### dv/pll_search_checker.sv
`timescale 1ns / 100ps
// Checker for pll_divider_search: mirrors the register file seen on the APB port,
// predicts the PLL setting for every accepted request and compares results in order.
// Depends on pds_pkg.
module pll_search_checker #(
	parameter int unsigned MAX_MULT    = pds_pkg::MAX_MULT_DEF,
	parameter int unsigned MAX_OUT_DIV = pds_pkg::MAX_OUT_DIV_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic [pds_pkg::FREQ_W-1:0]   fin_khz,
	input  logic [pds_pkg::NUM_W-1:0]    ratio_num,
	input  logic [pds_pkg::DEN_W-1:0]    ratio_den,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic                         found,
	input  logic [pds_pkg::SET_W-1:0]    multiplier,
	input  logic [pds_pkg::SET_W-1:0]    pre_divider,
	input  logic [pds_pkg::SET_W-1:0]    out_divider,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pds_pkg::ADDR_W-1:0]   paddr,
	input  logic [pds_pkg::DATA_W-1:0]   pwdata,
	input  logic [pds_pkg::DATA_W-1:0]   prdata,
	input  logic                         pready,
	output int                           outstanding,
	output int                           fail_count
);

	typedef struct packed {
		logic                     found;
		logic [pds_pkg::SET_W-1:0] mult;
		logic [pds_pkg::SET_W-1:0] prediv;
		logic [pds_pkg::SET_W-1:0] outdiv;
	} pll_setting_t;

	logic [pds_pkg::FREQ_W-1:0] vco_min, vco_max, pfd_min, pfd_max, fout_floor;
	pll_setting_t expected_settings[$];

	// first hit of the pre-divider / multiplier / output divider search
	function automatic pll_setting_t solve_pll(input logic [pds_pkg::FREQ_W-1:0] fin,
			input logic [pds_pkg::NUM_W-1:0] num, input logic [pds_pkg::DEN_W-1:0] den);
		pll_setting_t hit;
		longint unsigned f, d_lo, d_hi, m_lo, m_hi, lhs, q, o, fm;
		hit = '0;
		f = fin;
		if (f == 0)
			return hit;
		d_lo = (fin > pfd_max) ? 2 : 1;
		if (pfd_min == 0)
			d_hi = pds_pkg::DIV_CAP;
		else
			d_hi = f / pfd_min;
		if (d_hi == 0)
			d_hi = 1;
		if (d_hi > pds_pkg::DIV_CAP)
			d_hi = pds_pkg::DIV_CAP;
		for (longint unsigned d = d_lo; d <= d_hi; d++) begin
			m_lo = (vco_min * d + f - 1) / f;
			m_hi = (vco_max * d) / f;
			if (m_lo < 2)
				m_lo = 2;
			if (m_hi > MAX_MULT)
				m_hi = MAX_MULT;
			for (longint unsigned m = m_hi; m >= m_lo; m--) begin
				lhs = m * den;
				q = d * num;
				// zero numerator: only a zero product on the other side matches
				if (q == 0)
					o = (lhs == 0) ? 1 : 0;
				else if (lhs % q != 0)
					o = 0;
				else
					o = lhs / q;
				if (o > MAX_OUT_DIV)
					o = 0;
				fm = f * m;
				if (o != 0 && fm >= vco_min * d && fm <= vco_max * d
						&& fm >= fout_floor * d * o) begin
					hit.found  = 1'b1;
					hit.mult   = m[pds_pkg::SET_W-1:0];
					hit.prediv = d[pds_pkg::SET_W-1:0];
					hit.outdiv = o[pds_pkg::SET_W-1:0];
					return hit;
				end
			end
		end
		return hit;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pll_setting_t oldest;
		logic [pds_pkg::FREQ_W-1:0] reg_val;
		logic mapped;
		if (!arst_n) begin
			vco_min    = pds_pkg::VCO_MIN_RST;
			vco_max    = pds_pkg::VCO_MAX_RST;
			pfd_min    = pds_pkg::PFD_MIN_RST;
			pfd_max    = pds_pkg::PFD_MAX_RST;
			fout_floor = pds_pkg::FOUT_MIN_RST;
			expected_settings.delete();
			fail_count = 0;
			outstanding <= 0;
		end else begin
			if (in_valid && in_ready)
				expected_settings.push_back(solve_pll(fin_khz, ratio_num, ratio_den));
			if (out_valid && out_ready) begin
				if (expected_settings.size() == 0) begin
					$error("result with no request outstanding");
					fail_count++;
				end else begin
					oldest = expected_settings.pop_front();
					if (found !== oldest.found) begin
						$error("found: expected %0d, got %0d", oldest.found, found);
						fail_count++;
					end
					if (multiplier !== oldest.mult) begin
						$error("multiplier: expected %0d, got %0d", oldest.mult, multiplier);
						fail_count++;
					end
					if (pre_divider !== oldest.prediv) begin
						$error("pre_divider: expected %0d, got %0d", oldest.prediv, pre_divider);
						fail_count++;
					end
					if (out_divider !== oldest.outdiv) begin
						$error("out_divider: expected %0d, got %0d", oldest.outdiv, out_divider);
						fail_count++;
					end
				end
			end
			if (psel && penable && pready) begin
				mapped = 1'b1;
				reg_val = '0;
				case (paddr[pds_pkg::ADDR_W-1:2])
					pds_pkg::REG_VCO_MIN:  reg_val = vco_min;
					pds_pkg::REG_VCO_MAX:  reg_val = vco_max;
					pds_pkg::REG_PFD_MIN:  reg_val = pfd_min;
					pds_pkg::REG_PFD_MAX:  reg_val = pfd_max;
					pds_pkg::REG_FOUT_MIN: reg_val = fout_floor;
					default:               mapped = 1'b0;
				endcase
				if (pwrite) begin
					// unmapped indexes drop the write
					case (paddr[pds_pkg::ADDR_W-1:2])
						pds_pkg::REG_VCO_MIN:  vco_min    = pwdata[pds_pkg::FREQ_W-1:0];
						pds_pkg::REG_VCO_MAX:  vco_max    = pwdata[pds_pkg::FREQ_W-1:0];
						pds_pkg::REG_PFD_MIN:  pfd_min    = pwdata[pds_pkg::FREQ_W-1:0];
						pds_pkg::REG_PFD_MAX:  pfd_max    = pwdata[pds_pkg::FREQ_W-1:0];
						pds_pkg::REG_FOUT_MIN: fout_floor = pwdata[pds_pkg::FREQ_W-1:0];
						default: ;
					endcase
				end else if (mapped && prdata !== {{(pds_pkg::DATA_W-pds_pkg::FREQ_W){1'b0}}, reg_val}) begin
					$error("prdata at 0x%0h: expected %0d, got %0d", paddr, reg_val, prdata);
					fail_count++;
				end
			end
			outstanding <= expected_settings.size();
		end
	end

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// Testbench top for pll_divider_search: clock, reset, register writes, directed and
// random requests with idle bursts, and the verdict. Depends on pds_pkg and pll_search_checker.
module tb;

	typedef logic [pds_pkg::FREQ_W-1:0] freq_t;
	typedef logic [pds_pkg::NUM_W-1:0]  num_t;
	typedef logic [pds_pkg::DEN_W-1:0]  den_t;

	localparam longint unsigned FMAX = (longint'(1) << pds_pkg::FREQ_W) - 1;
	// limit on the run length; past it the run stops and reports failure
	localparam longint unsigned CYCLE_LIMIT = 200_000_000;
	localparam int unsigned RANDOM_PHASES = 6;
	localparam int unsigned PHASE_ITEMS   = 45;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [pds_pkg::FREQ_W-1:0] fin_khz = '0;
	logic [pds_pkg::NUM_W-1:0] ratio_num = '0;
	logic [pds_pkg::DEN_W-1:0] ratio_den = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic found;
	logic [pds_pkg::SET_W-1:0] multiplier, pre_divider, out_divider;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [pds_pkg::ADDR_W-1:0] paddr = '0;
	logic [pds_pkg::DATA_W-1:0] pwdata = '0;
	logic [pds_pkg::DATA_W-1:0] prdata;
	logic pready;
	int outstanding;
	int fail_count;

	logic stall_en = 1'b0;
	bit gaps_on;
	int stall_left;
	longint unsigned cycles = 0;
	freq_t cfg [0:4];

	pll_divider_search dut (.*);
	pll_search_checker chk (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// result side: when stalls are enabled, hold out_ready low for bursts of random length
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else if (stall_en && $urandom_range(0, 3) == 0) begin
			out_ready <= 1'b0;
			stall_left <= $urandom_range(0, 4);
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic apb_xfer(input logic [2:0] idx, input logic wr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic cfg_write(input logic [2:0] idx, input freq_t val);
		logic [31:0] data;
		data = $urandom();
		data[pds_pkg::FREQ_W-1:0] = val;
		if (idx <= pds_pkg::REG_FOUT_MIN)
			cfg[idx] = val;
		apb_xfer(idx, 1'b1, data);
	endtask

	task automatic read_regs();
		for (int i = pds_pkg::REG_VCO_MIN; i <= pds_pkg::REG_FOUT_MIN; i++)
			apb_xfer(3'(i), 1'b0, '0);
	endtask

	task automatic set_config(input freq_t vmin, input freq_t vmax, input freq_t pmin,
			input freq_t pmax, input freq_t fmin);
		cfg_write(pds_pkg::REG_VCO_MIN, vmin);
		cfg_write(pds_pkg::REG_VCO_MAX, vmax);
		cfg_write(pds_pkg::REG_PFD_MIN, pmin);
		cfg_write(pds_pkg::REG_PFD_MAX, pmax);
		cfg_write(pds_pkg::REG_FOUT_MIN, fmin);
		read_regs();
	endtask

	task automatic send_request(input freq_t f, input num_t n, input den_t d);
		int gap;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		fin_khz <= f;
		ratio_num <= n;
		ratio_den <= d;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// drop valid and wait until every outstanding request has its result
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		longint unsigned f, hi, dmax, dt, mt, ot, mlo, mhi, a, b, t, nn, dd, k;
		int kind;
		gaps_on = 1'b1;
		cfg[pds_pkg::REG_VCO_MIN]  = pds_pkg::VCO_MIN_RST;
		cfg[pds_pkg::REG_VCO_MAX]  = pds_pkg::VCO_MAX_RST;
		cfg[pds_pkg::REG_PFD_MIN]  = pds_pkg::PFD_MIN_RST;
		cfg[pds_pkg::REG_PFD_MAX]  = pds_pkg::PFD_MAX_RST;
		cfg[pds_pkg::REG_FOUT_MIN] = pds_pkg::FOUT_MIN_RST;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		stall_en <= 1'b1;
		@(posedge clk);
		read_regs();

		// reset settings: zero clock, plain hits, pre-divider from two, extremes
		send_request(22'd0, 12'd1, 16'd1);
		send_request(22'd100000, 12'd1, 16'd1);
		send_request(22'd500000, 12'd1, 16'd1);
		send_request(22'd200000, 12'd1, 16'd2);
		send_request(22'd4194303, 12'd4095, 16'd65535);
		send_request(22'd1, 12'd1, 16'd1);
		send_request(22'd100000, 12'd0, 16'd0);
		send_request(22'd100000, 12'd0, 16'd1);
		send_request(22'd100000, 12'd1, 16'd0);
		send_request(22'd1000000, 12'd4095, 16'd1);
		send_request(22'd100000, 12'd1, 16'd65535);
		drain();

		// widest window, smallest phase detector bound, unmapped writes
		set_config('0, freq_t'(FMAX), 22'd1, '0, '0);
		for (int i = pds_pkg::REG_FOUT_MIN + 1; i < (1 << $bits(pds_pkg::reg_idx_t)); i++)
			cfg_write(3'(i), freq_t'($urandom()));
		read_regs();
		send_request(22'd3, 12'd1, 16'd1);
		send_request(22'd2, 12'd4095, 16'd1);
		send_request(22'd4194303, 12'd1, 16'd1);
		send_request(22'd0, 12'd4095, 16'd65535);
		drain();

		// zero phase detector bound saturates the pre-divider at its cap
		set_config(freq_t'(FMAX), freq_t'(FMAX), '0, freq_t'(FMAX), freq_t'(FMAX));
		send_request(22'd1000, 12'd1, 16'd1);
		send_request(22'd4194303, 12'd1, 16'd1);
		send_request(22'd4194303, 12'd1, 16'd2);
		drain();

		// largest phase detector bound: empty pre-divider range above pfd_max
		set_config(pds_pkg::VCO_MIN_RST, pds_pkg::VCO_MAX_RST, freq_t'(FMAX),
			pds_pkg::PFD_MAX_RST, pds_pkg::FOUT_MIN_RST);
		send_request(22'd4194303, 12'd1, 16'd1);
		send_request(22'd100000, 12'd1, 16'd1);
		drain();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			if (ph == RANDOM_PHASES - 1) begin
				gaps_on = 1'b0;
				stall_en <= 1'b0;
			end
			if (ph == 0) begin
				set_config(pds_pkg::VCO_MIN_RST, pds_pkg::VCO_MAX_RST, pds_pkg::PFD_MIN_RST,
					pds_pkg::PFD_MAX_RST, pds_pkg::FOUT_MIN_RST);
			end else begin
				a = $urandom_range(100000, 1200000);
				b = a + $urandom_range(0, 600000);
				t = ($urandom_range(0, 3) == 0) ? $urandom_range(0, FMAX) : $urandom_range(0, 50000);
				set_config(freq_t'(a), freq_t'(b), freq_t'($urandom_range(50000, 300000)),
					freq_t'($urandom_range(0, FMAX)), freq_t'(t));
			end
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				kind = $urandom_range(0, 99);
				hi = 16 * longint'(cfg[pds_pkg::REG_PFD_MIN]);
				if (hi > FMAX)
					hi = FMAX;
				f = $urandom_range(cfg[pds_pkg::REG_PFD_MIN], hi);
				if (kind < 70) begin
					// well formed: ratio built from a setting inside the window
					dmax = f / cfg[pds_pkg::REG_PFD_MIN];
					if (dmax < 1)
						dmax = 1;
					dt = $urandom_range(1, dmax);
					mlo = (cfg[pds_pkg::REG_VCO_MIN] * dt + f - 1) / f;
					mhi = (cfg[pds_pkg::REG_VCO_MAX] * dt) / f;
					if (mlo < 2)
						mlo = 2;
					if (mhi > pds_pkg::MAX_MULT_DEF)
						mhi = pds_pkg::MAX_MULT_DEF;
					if (mhi >= mlo)
						mt = $urandom_range(mlo, mhi);
					else
						mt = $urandom_range(2, pds_pkg::MAX_MULT_DEF);
					if ($urandom_range(0, 3) == 0)
						ot = $urandom_range(1, pds_pkg::MAX_OUT_DIV_DEF);
					else
						ot = $urandom_range(1, 16);
					a = mt;
					b = dt * ot;
					while (b != 0) begin
						t = a % b;
						a = b;
						b = t;
					end
					nn = mt / a;
					dd = dt * ot / a;
					t = 4095 / nn;
					if (65535 / dd < t)
						t = 65535 / dd;
					if (t > 8)
						t = 8;
					k = $urandom_range(1, t);
					send_request(freq_t'(f), num_t'(nn * k), den_t'(dd * k));
				end else if (kind < 85) begin
					send_request(freq_t'(f), num_t'($urandom_range(1, 4095)),
						den_t'($urandom_range(1, 65535)));
				end else begin
					// noise: any field value, zeros included
					if ($urandom_range(0, 3) == 0)
						f = $urandom_range(0, FMAX);
					else
						f = $urandom_range(0, 1500000);
					send_request(freq_t'(f), num_t'($urandom()), den_t'($urandom()));
				end
			end
			drain();
		end

		repeat (50) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

### sim.f
sv/pds_pkg.sv
sv/pll_divider_search.sv
dv/pll_search_checker.sv
dv/tb.sv
